// ===== design/bcst_pkg.sv =====
// Shared types and constants of the battery charge state tracker.
// No dependencies; used by bcst_div and battery_charge_state_tracker_unit.
package bcst_pkg;

    // Fraction format: unsigned fixed point with FRAC_BITS fraction bits
    localparam int FRAC_BITS = 15;
    localparam int OUT_W     = 16;
    localparam logic [OUT_W-1:0] FRAC_ONE = OUT_W'(64'd1 << FRAC_BITS);

    // Serial divider operand width (positive values below 2^15)
    localparam int DIV_W = 15;
    localparam int CNT_W = $clog2(FRAC_BITS);

    // Configuration register indexes
    localparam logic REG_EMPTY_V = 1'b0;
    localparam logic REG_FULL_V  = 1'b1;

    localparam logic [13:0] EMPTY_V_RESET = 14'd3000;
    localparam logic [13:0] FULL_V_RESET  = 14'd4200;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] quot;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_M_START,
        ST_M_WAIT,
        ST_V_START,
        ST_V_WAIT,
        ST_DONE
    } state_t;

endpackage

// ===== design/battery_charge_state_tracker_unit.sv =====
// Top level of the battery charge state tracker (coulomb-counter fuel gauge).
// Depends on bcst_pkg and bcst_div.

// One request per gauge sample yields one result. The state updates (empty
// reference, learned full capacity, measured charge) are settled in the cycle
// the request is accepted; the two fractions are then worked out one after
// the other on a single shared bit-serial divider that produces one quotient
// bit per cycle. A sample that needs no division (no battery, clamped or
// boundary cases) goes from ST_M_START through ST_V_START to ST_DONE; one
// that needs both divisions also passes ST_M_WAIT and ST_V_WAIT. Fractions
// are unsigned Q1.15 at the default format. The next request is taken in the
// cycle after the result is loaded. One sample is in work at a time, but a
// finished result waits in the output register, so the next request is taken
// while the previous result is still unclaimed. Configuration writes are
// taken at any edge and apply to requests accepted afterwards.
module battery_charge_state_tracker_unit
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [13:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] charge_count_mah,
    input  logic signed [15:0] current_ma,
    input  logic [13:0]        voltage_mv,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               status,
    output logic               charging,
    output logic [15:0]        measured_fraction,
    output logic               measured_known,
    output logic [15:0]        voltage_fraction,
    output logic               save_request
);

    // Configuration registers
    logic [13:0] empty_v_reg;
    logic [13:0] full_v_reg;

    // Tracked state; the empty reference is only ever unknown or zero
    logic               ref_known_reg,  ref_known_next;
    logic signed [16:0] full_cap_reg,   full_cap_next;
    logic signed [16:0] meas_charge_reg, meas_charge_next;
    logic [15:0]        last_frac_reg,  last_frac_next;
    logic               meas_valid_reg, meas_valid_next;

    bcst_pkg::state_t state_reg, state_next;

    // Pending result and division jobs of the sample in work
    logic                       res_status_reg,   res_status_next;
    logic                       res_charging_reg, res_charging_next;
    logic                       res_save_reg,     res_save_next;
    logic [15:0]                vfrac_reg,        vfrac_next;
    logic                       m_div_reg,        m_div_next;
    logic                       v_div_reg,        v_div_next;
    logic [bcst_pkg::DIV_W-1:0] m_num_reg,        m_num_next;
    logic [bcst_pkg::DIV_W-1:0] m_den_reg,        m_den_next;
    logic [bcst_pkg::DIV_W-1:0] v_num_reg,        v_num_next;
    logic [bcst_pkg::DIV_W-1:0] v_den_reg,        v_den_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        status_reg;
    logic        charging_reg;
    logic [15:0] mfrac_out_reg;
    logic        mknown_out_reg;
    logic [15:0] vfrac_out_reg;
    logic        save_out_reg;
    logic        out_load;

    bcst_pkg::div_req_t div_req;
    bcst_pkg::div_rsp_t div_rsp;

    // Sample decode for the accept cycle
    logic               accept;
    logic               volt_zero;
    logic               at_empty;
    logic               at_full;
    logic               ref_after;
    logic signed [16:0] count_ext;
    logic signed [16:0] cap_after;
    logic               save_acc;
    logic [13:0]        v_span;
    logic [13:0]        v_off;

    bcst_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept    = in_valid && in_ready;
    assign volt_zero = (voltage_mv == 14'd0);
    assign at_empty  = (voltage_mv <= empty_v_reg);
    assign at_full   = (voltage_mv >= full_v_reg);
    assign count_ext = 17'(charge_count_mah);
    assign v_span    = full_v_reg - empty_v_reg;
    assign v_off     = voltage_mv - empty_v_reg;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_v_reg <= bcst_pkg::EMPTY_V_RESET;
            full_v_reg  <= bcst_pkg::FULL_V_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bcst_pkg::REG_EMPTY_V: empty_v_reg <= cfg_data;
                bcst_pkg::REG_FULL_V:  full_v_reg  <= cfg_data;
                default:               empty_v_reg <= empty_v_reg;
            endcase
        end
    end

    // Next state and outputs of the sequencer
    always_comb
    begin
        state_next        = state_reg;
        ref_known_next    = ref_known_reg;
        full_cap_next     = full_cap_reg;
        meas_charge_next  = meas_charge_reg;
        last_frac_next    = last_frac_reg;
        meas_valid_next   = meas_valid_reg;
        res_status_next   = res_status_reg;
        res_charging_next = res_charging_reg;
        res_save_next     = res_save_reg;
        vfrac_next        = vfrac_reg;
        m_div_next        = m_div_reg;
        v_div_next        = v_div_reg;
        m_num_next        = m_num_reg;
        m_den_next        = m_den_reg;
        v_num_next        = v_num_reg;
        v_den_next        = v_den_reg;
        div_req.start     = 1'b0;
        div_req.num       = m_num_reg;
        div_req.den       = m_den_reg;
        in_ready          = 1'b0;
        out_load          = 1'b0;
        ref_after         = ref_known_reg;
        cap_after         = full_cap_reg;
        save_acc          = 1'b0;

        case (state_reg)
            bcst_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                // empty rule first; full rule only when not empty
                ref_after = ref_known_reg || at_empty;
                if (!at_empty && at_full && ref_known_reg)
                begin
                    cap_after = count_ext;
                end
                if (accept)
                begin
                    res_status_next   = volt_zero;
                    res_charging_next = !volt_zero && (current_ma > 16'sd0);
                    m_div_next        = 1'b0;
                    v_div_next        = 1'b0;
                    vfrac_next        = '0;
                    if (!volt_zero)
                    begin
                        if (at_empty && !ref_known_reg)
                        begin
                            save_acc = 1'b1;
                        end
                        if (cap_after != full_cap_reg)
                        begin
                            save_acc = 1'b1;
                        end
                        ref_known_next = ref_after;
                        full_cap_next  = cap_after;
                        if (ref_after && (cap_after > 17'sd0))
                        begin
                            if (meas_charge_reg != count_ext)
                            begin
                                save_acc = 1'b1;
                            end
                            meas_charge_next = count_ext;
                            meas_valid_next  = 1'b1;
                            if (count_ext <= 17'sd0)
                            begin
                                last_frac_next = '0;
                            end
                            else if (count_ext >= cap_after)
                            begin
                                last_frac_next = bcst_pkg::FRAC_ONE;
                            end
                            else
                            begin
                                // 0 < count < cap, both below 2^15
                                m_div_next = 1'b1;
                                m_num_next = charge_count_mah[bcst_pkg::DIV_W-1:0];
                                m_den_next = cap_after[bcst_pkg::DIV_W-1:0];
                            end
                        end
                        if (at_empty)
                        begin
                            vfrac_next = '0;
                        end
                        else if (at_full)
                        begin
                            vfrac_next = bcst_pkg::FRAC_ONE;
                        end
                        else
                        begin
                            v_div_next = 1'b1;
                            v_num_next = bcst_pkg::DIV_W'(v_off);
                            v_den_next = bcst_pkg::DIV_W'(v_span);
                        end
                    end
                    res_save_next = save_acc;
                    state_next    = bcst_pkg::ST_M_START;
                end
            end

            bcst_pkg::ST_M_START:
            begin
                if (m_div_reg)
                begin
                    div_req.start = 1'b1;
                    state_next    = bcst_pkg::ST_M_WAIT;
                end
                else
                begin
                    state_next = bcst_pkg::ST_V_START;
                end
            end

            bcst_pkg::ST_M_WAIT:
            begin
                if (div_rsp.done)
                begin
                    last_frac_next = 16'(div_rsp.quot);
                    state_next     = bcst_pkg::ST_V_START;
                end
            end

            bcst_pkg::ST_V_START:
            begin
                div_req.num = v_num_reg;
                div_req.den = v_den_reg;
                if (v_div_reg)
                begin
                    div_req.start = 1'b1;
                    state_next    = bcst_pkg::ST_V_WAIT;
                end
                else
                begin
                    state_next = bcst_pkg::ST_DONE;
                end
            end

            bcst_pkg::ST_V_WAIT:
            begin
                if (div_rsp.done)
                begin
                    vfrac_next = 16'(div_rsp.quot);
                    state_next = bcst_pkg::ST_DONE;
                end
            end

            bcst_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = bcst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bcst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and tracked values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bcst_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            ref_known_reg   <= 1'b0;
            full_cap_reg    <= '1;
            meas_charge_reg <= '1;
            last_frac_reg   <= '0;
            meas_valid_reg  <= 1'b0;
            m_div_reg       <= 1'b0;
            v_div_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            ref_known_reg   <= ref_known_next;
            full_cap_reg    <= full_cap_next;
            meas_charge_reg <= meas_charge_next;
            last_frac_reg   <= last_frac_next;
            meas_valid_reg  <= meas_valid_next;
            m_div_reg       <= m_div_next;
            v_div_reg       <= v_div_next;
        end
    end

    // Payload of the sample in work and of the output register
    always_ff @(posedge clk)
    begin
        res_status_reg   <= res_status_next;
        res_charging_reg <= res_charging_next;
        res_save_reg     <= res_save_next;
        vfrac_reg        <= vfrac_next;
        m_num_reg        <= m_num_next;
        m_den_reg        <= m_den_next;
        v_num_reg        <= v_num_next;
        v_den_reg        <= v_den_next;
        if (out_load)
        begin
            status_reg     <= res_status_reg;
            charging_reg   <= res_charging_reg;
            mfrac_out_reg  <= last_frac_reg;
            mknown_out_reg <= meas_valid_reg;
            vfrac_out_reg  <= vfrac_reg;
            save_out_reg   <= res_save_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign charging          = charging_reg;
    assign measured_fraction = mfrac_out_reg;
    assign measured_known    = mknown_out_reg;
    assign voltage_fraction  = vfrac_out_reg;
    assign save_request      = save_out_reg;

endmodule

// ===== design/bcst_div.sv =====
// Bit-serial restoring divider: floor((num << FRAC_BITS) / den) for num < den.
// Depends on bcst_pkg; one quotient bit per cycle.
module bcst_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  bcst_pkg::div_req_t  req,
    output bcst_pkg::div_rsp_t  rsp
);

    logic [bcst_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [bcst_pkg::DIV_W-1:0]     den_reg, den_next;
    logic [bcst_pkg::FRAC_BITS-1:0] quot_reg, quot_next;
    logic [bcst_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [bcst_pkg::DIV_W:0]       rem2;
    logic [bcst_pkg::DIV_W:0]       diff;
    logic                           fits;

    always_comb
    begin
        rem2      = {rem_reg, 1'b0};
        diff      = rem2 - {1'b0, den_reg};
        fits      = (rem2 >= {1'b0, den_reg});
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below den, so it fits DIV_W bits
            rem_next  = fits ? diff[bcst_pkg::DIV_W-1:0] : rem2[bcst_pkg::DIV_W-1:0];
            quot_next = {quot_reg[bcst_pkg::FRAC_BITS-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == bcst_pkg::CNT_W'(bcst_pkg::FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
